// File: sv/slp_pkg.sv
// Package for the status line parser: character codes, prefix patterns,
// result codes and the types shared by the top level and the fault scanner.
// No dependencies.
package slp_pkg;

    // Default line buffer size in bytes, including room for the terminator
    localparam int LINE_BYTES_DEF = 128;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_F     = 8'h46;

    // Prefix patterns, left-justified in eight bytes, zero padded
    localparam int          PFX_COUNT  = 7;
    localparam logic [2:0]  PFX_ZHOMED = 3'd6;
    localparam logic [63:0] PAT_OTA_IP  = {"OTA_IP:", 8'h00};
    localparam logic [63:0] PAT_OTA_ERR = "OTA_ERR:";
    localparam logic [63:0] PAT_OTA_END = "OTA_END:";
    localparam logic [63:0] PAT_ERR     = {"ERR:", 32'h0};
    localparam logic [63:0] PAT_WARN    = {"WARN:", 24'h0};
    localparam logic [63:0] PAT_MSG     = {"MSG:", 32'h0};
    localparam logic [63:0] PAT_ZHOMED  = {"ZHOMED", 16'h0};

    // Fault magnitude saturates here; at or above it the long range is exceeded
    localparam logic [31:0] MAG_SAT = 32'h8000_0000;

    // Line classes, in match priority order
    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_OTA_IP  = 3'd1,
        KIND_OTA_ERR = 3'd2,
        KIND_OTA_END = 3'd3,
        KIND_ERR     = 3'd4,
        KIND_WARN    = 3'd5,
        KIND_MSG     = 3'd6
    } t_line_kind;

    typedef enum logic [1:0] {
        ZH_NONE    = 2'd0,
        ZH_ACCEPT  = 2'd1,
        ZH_IGNORED = 2'd2
    } t_zhome;

    // Fault field scan phases
    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_SEENF  = 3'd1,
        PH_SPACE  = 3'd2,
        PH_SIGN   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } t_scan_phase;

    // Strobes from the line control into the fault scanner
    typedef struct packed {
        logic step;   // byte taken into the line
        logic clear;  // line finished or dropped
    } t_scan_ctl;

    // Fault status of the line in progress
    typedef struct packed {
        logic       present;
        logic [7:0] value;
    } t_fault_stat;

    function automatic logic [63:0] pat_row(input logic [2:0] k);
        logic [63:0] row;
        case (k)
            3'd0:    row = PAT_OTA_IP;
            3'd1:    row = PAT_OTA_ERR;
            3'd2:    row = PAT_OTA_END;
            3'd3:    row = PAT_ERR;
            3'd4:    row = PAT_WARN;
            3'd5:    row = PAT_MSG;
            3'd6:    row = PAT_ZHOMED;
            default: row = '0;
        endcase
        return row;
    endfunction

    function automatic logic [7:0] pat_char(input logic [2:0] k, input logic [2:0] pos);
        logic [63:0] row;
        row = pat_row(k);
        return row[(63 - 8 * int'(pos)) -: 8];
    endfunction

    function automatic logic [3:0] pat_len(input logic [2:0] k);
        logic [3:0] len;
        case (k)
            3'd0:    len = 4'd7;
            3'd1:    len = 4'd8;
            3'd2:    len = 4'd8;
            3'd3:    len = 4'd4;
            3'd4:    len = 4'd5;
            3'd5:    len = 4'd4;
            3'd6:    len = 4'd6;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// File: sv/slp_fault_scan.sv
// Fault field scanner: finds the first "F:" in a line and reads the signed
// decimal number after it the way strtol does, kept to eight bits.
// Depends on slp_pkg.
module slp_fault_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slp_pkg::t_scan_ctl   i_ctl,
    input  logic [7:0]           i_byte,
    output slp_pkg::t_fault_stat o_stat
);
    import slp_pkg::*;

    t_scan_phase r_phase, n_phase;
    logic [31:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    logic        r_ended, n_ended;

    logic        w_digit;
    logic        w_blank;
    logic [35:0] w_mag_x10;
    logic [31:0] w_mag_add;

    assign w_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_blank = (i_byte == CH_SPACE) || (i_byte == CH_TAB) ||
                     (i_byte == CH_VT) || (i_byte == CH_FF);

    // magnitude * 10 + digit, saturating
    assign w_mag_x10 = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) +
                       36'(i_byte - CH_ZERO);
    assign w_mag_add = (w_mag_x10 > 36'(MAG_SAT)) ? MAG_SAT : w_mag_x10[31:0];

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_ended = r_ended;
        if (i_ctl.clear) begin
            n_phase = PH_SEARCH;
            n_mag   = '0;
            n_neg   = 1'b0;
            n_ended = 1'b0;
        end else if (i_ctl.step && !r_ended) begin
            if (i_byte == CH_NUL) begin
                // a zero byte ends the visible text
                n_ended = 1'b1;
            end else begin
                case (r_phase)
                    PH_SEARCH: begin
                        if (i_byte == CH_F) n_phase = PH_SEENF;
                    end
                    PH_SEENF: begin
                        if (i_byte == CH_COLON) n_phase = PH_SPACE;
                        else if (i_byte != CH_F) n_phase = PH_SEARCH;
                    end
                    PH_SPACE: begin
                        if (w_blank) begin
                            n_phase = PH_SPACE;
                        end else if (i_byte == CH_PLUS) begin
                            n_phase = PH_SIGN;
                        end else if (i_byte == CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGN;
                        end else if (w_digit) begin
                            n_mag   = w_mag_add;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_SIGN: begin
                        if (w_digit) begin
                            n_mag   = w_mag_add;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_DIGITS: begin
                        if (w_digit) n_mag = w_mag_add;
                        else n_phase = PH_DONE;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // Outputs: present once past "F:", value from the saturated magnitude
    always_comb begin
        o_stat.present = (r_phase == PH_SPACE) || (r_phase == PH_SIGN) ||
                         (r_phase == PH_DIGITS) || (r_phase == PH_DONE);
        if (r_neg) begin
            o_stat.value = r_mag[31] ? 8'h00 : 8'(8'h00 - r_mag[7:0]);
        end else begin
            o_stat.value = r_mag[31] ? 8'hFF : r_mag[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_ended <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_ended <= n_ended;
        end
    end

    // A sign is only recorded once the scan is past "F:"
    a_neg_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_neg |-> (r_phase == PH_SIGN) || (r_phase == PH_DIGITS) || (r_phase == PH_DONE))
        else $error("negative flag outside number phases");

    // Magnitude never passes the saturation point
    a_mag_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mag[31] |-> (r_mag == MAG_SAT))
        else $error("fault magnitude beyond saturation");

endmodule

// File: sv/status_line_parser_unit.sv
// Status line parser top level: byte handshake in, one registered result per
// finished or dropped line out. Depends on slp_pkg and slp_fault_scan.
//
// Takes one received byte per cycle, every cycle, as long as the result
// register is empty or being taken in the same cycle. A newline loads the
// result register on its beat; any other byte but a carriage return arriving
// with LINE_BYTES-1 characters held gives an overflow result instead. Carriage
// returns and ordinary characters produce none. All per-byte work (prefix
// compare, fault digit multiply-add by ten) sits between the accepted beat and
// the line state and result registers, so throughput is one byte per clock.
module status_line_parser_unit #(
    parameter int LINE_BYTES = slp_pkg::LINE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_machine_quiet,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_line_kind,
    output logic       o_overflowed,
    output logic       o_link_first,
    output logic [1:0] o_zhome_status,
    output logic       o_fault_present,
    output logic [7:0] o_fault_value,
    output logic       o_fault_alarm,
    output logic [6:0] o_line_length
);
    import slp_pkg::*;

    localparam int CW = $clog2(LINE_BYTES);

    // Line state
    logic [CW-1:0]        r_count, n_count;
    logic [PFX_COUNT-1:0] r_alive, n_alive;
    logic                 r_link_up, n_link_up;
    logic [7:0]           r_prev_fault, n_prev_fault;

    // Result register
    logic       r_out_valid, n_out_valid;
    t_line_kind r_line_kind, n_line_kind;
    logic       r_overflowed, n_overflowed;
    logic       r_link_first, n_link_first;
    t_zhome     r_zhome, n_zhome;
    logic       r_fault_present, n_fault_present;
    logic [7:0] r_fault_value, n_fault_value;
    logic       r_fault_alarm, n_fault_alarm;
    logic [6:0] r_line_length, n_line_length;

    logic                 w_fire, w_cr, w_lf, w_full, w_take, w_ovf, w_eol;
    logic [PFX_COUNT-1:0] w_hit;
    t_line_kind           w_kind;
    t_scan_ctl            w_ctl;
    t_fault_stat          w_fault;

    // Beat decode
    assign o_ready = !r_out_valid || i_ready;
    assign w_fire  = i_valid && o_ready;
    assign w_cr    = (i_rx_byte == CH_CR);
    assign w_lf    = (i_rx_byte == CH_LF);
    assign w_full  = (r_count >= CW'(LINE_BYTES - 1));
    assign w_take  = w_fire && !w_cr && !w_lf && !w_full;
    assign w_ovf   = w_fire && !w_cr && !w_lf && w_full;
    assign w_eol   = w_fire && w_lf;

    assign w_ctl.step  = w_take;
    assign w_ctl.clear = w_ovf || w_eol;

    slp_fault_scan u_fault_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_byte (i_rx_byte),
        .o_stat (w_fault)
    );

    // Prefix hits and priority class
    always_comb begin
        for (int k = 0; k < PFX_COUNT; k++) begin
            w_hit[k] = r_alive[k] && (r_count >= CW'(pat_len(3'(k))));
        end
        w_kind = KIND_NONE;
        for (int k = PFX_COUNT - 2; k >= 0; k--) begin
            if (w_hit[k]) w_kind = t_line_kind'(3'(k + 1));
        end
    end

    // Line state update
    always_comb begin
        n_count      = r_count;
        n_alive      = r_alive;
        n_link_up    = r_link_up;
        n_prev_fault = r_prev_fault;
        if (w_ovf || w_eol) begin
            n_count = '0;
            n_alive = '1;
            if (w_eol && (r_count != '0)) n_link_up = 1'b1;
            if (w_eol && w_fault.present) n_prev_fault = w_fault.value;
        end else if (w_take) begin
            n_count = r_count + CW'(1);
            for (int k = 0; k < PFX_COUNT; k++) begin
                if ((r_count < CW'(pat_len(3'(k)))) &&
                    (i_rx_byte != pat_char(3'(k), r_count[2:0]))) begin
                    n_alive[k] = 1'b0;
                end
            end
        end
    end

    // Result register load
    always_comb begin
        n_out_valid     = r_out_valid && !i_ready;
        n_line_kind     = r_line_kind;
        n_overflowed    = r_overflowed;
        n_link_first    = r_link_first;
        n_zhome         = r_zhome;
        n_fault_present = r_fault_present;
        n_fault_value   = r_fault_value;
        n_fault_alarm   = r_fault_alarm;
        n_line_length   = r_line_length;
        if (w_ovf) begin
            n_out_valid     = 1'b1;
            n_line_kind     = KIND_NONE;
            n_overflowed    = 1'b1;
            n_link_first    = 1'b0;
            n_zhome         = ZH_NONE;
            n_fault_present = 1'b0;
            n_fault_value   = '0;
            n_fault_alarm   = 1'b0;
            n_line_length   = '0;
        end else if (w_eol) begin
            n_out_valid     = 1'b1;
            n_line_kind     = w_kind;
            n_overflowed    = 1'b0;
            n_link_first    = !r_link_up && (r_count != '0);
            if (!w_hit[PFX_ZHOMED]) n_zhome = ZH_NONE;
            else if (i_machine_quiet) n_zhome = ZH_ACCEPT;
            else n_zhome = ZH_IGNORED;
            n_fault_present = w_fault.present;
            n_fault_value   = w_fault.present ? w_fault.value : 8'h00;
            n_fault_alarm   = w_fault.present && (w_fault.value != 8'h00) &&
                              (r_prev_fault == 8'h00);
            n_line_length   = 7'(r_count);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_alive      <= '1;
            r_link_up    <= 1'b0;
            r_prev_fault <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_alive      <= n_alive;
            r_link_up    <= n_link_up;
            r_prev_fault <= n_prev_fault;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_line_kind     <= n_line_kind;
        r_overflowed    <= n_overflowed;
        r_link_first    <= n_link_first;
        r_zhome         <= n_zhome;
        r_fault_present <= n_fault_present;
        r_fault_value   <= n_fault_value;
        r_fault_alarm   <= n_fault_alarm;
        r_line_length   <= n_line_length;
    end

    assign o_valid         = r_out_valid;
    assign o_line_kind     = r_line_kind;
    assign o_overflowed    = r_overflowed;
    assign o_link_first    = r_link_first;
    assign o_zhome_status  = r_zhome;
    assign o_fault_present = r_fault_present;
    assign o_fault_value   = r_fault_value;
    assign o_fault_alarm   = r_fault_alarm;
    assign o_line_length   = r_line_length;

    // Overflow beats carry nothing else
    a_ovf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_overflowed) |->
            (r_line_kind == KIND_NONE) && !r_link_first && !r_fault_present &&
            (r_zhome == ZH_NONE))
        else $error("overflow result with line fields set");

    // Alarm only with a nonzero fault code
    a_alarm_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fault_alarm) |-> r_fault_present && (r_fault_value != 8'h00))
        else $error("alarm without nonzero fault code");

    // Link confirmation latches with the first non-empty line
    a_link_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_link_first) |-> r_link_up)
        else $error("link_first without link up");

    // Line count stays inside the buffer
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LINE_BYTES - 1))
        else $error("line count beyond buffer");

endmodule

// File: verif/slp_line_checker.sv
// Scoreboard for the status line parser: watches the byte and result channels,
// predicts one report per finished or dropped line and compares result beats.
// Depends on slp_pkg.
module slp_line_checker #(
    parameter int LINE_BYTES = slp_pkg::LINE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic       i_byte_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_machine_quiet,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [2:0] i_line_kind,
    input  logic       i_overflowed,
    input  logic       i_link_first,
    input  logic [1:0] i_zhome_status,
    input  logic       i_fault_present,
    input  logic [7:0] i_fault_value,
    input  logic       i_fault_alarm,
    input  logic [6:0] i_line_length,
    output int         o_fail_count,
    output int         o_pending
);
    import slp_pkg::*;

    typedef struct packed {
        t_line_kind  kind;
        logic        overflowed;
        logic        link_first;
        t_zhome      zhome;
        logic        fault_present;
        logic [7:0]  fault_value;
        logic        fault_alarm;
        logic [6:0]  length;
    } t_line_report;

    // Prefix spellings (leftmost entry first, zero padded) and their lengths
    localparam logic [0:6][63:0] PREFIX_TEXT = {
        {"OTA_IP:", 8'h00}, "OTA_ERR:", "OTA_END:", {"ERR:", 32'h0},
        {"WARN:", 24'h0}, {"MSG:", 32'h0}, {"ZHOMED", 16'h0}
    };
    localparam logic [0:6][3:0] PREFIX_LEN = {
        4'd7, 4'd8, 4'd8, 4'd4, 4'd5, 4'd4, 4'd6
    };

    // Magnitude cap, one past the largest negative long
    localparam logic [31:0] MAG_CAP = 32'h8000_0001;

    t_line_report awaited_reports[$];
    int unsigned  line_len;
    logic [6:0]   live_prefixes;
    t_scan_phase  scan_phase;
    logic [31:0]  fault_mag;
    logic         fault_neg;
    logic [7:0]   last_fault;
    logic         link_seen;
    logic         text_cut;
    int           fail_total = 0;

    task automatic restart_line();
        line_len      = 0;
        live_prefixes = '1;
        scan_phase    = PH_SEARCH;
        fault_mag     = '0;
        fault_neg     = 1'b0;
        text_cut      = 1'b0;
    endtask

    function automatic logic [31:0] grow_fault(input logic [31:0] mag,
                                               input logic [7:0] digit);
        logic [63:0] wide;
        wide = 64'(mag) * 64'd10 + 64'(digit - CH_ZERO);
        return (wide > 64'(MAG_CAP)) ? MAG_CAP : wide[31:0];
    endfunction

    function automatic logic prefix_hit(input int k);
        return live_prefixes[k] && (line_len >= PREFIX_LEN[k]);
    endfunction

    // Advance the line state by one accepted byte; queue a report if one is due
    task automatic take_byte(input logic [7:0] b, input logic quiet);
        t_line_report rep;
        logic [7:0]   code;
        logic         digit;
        logic         blank;
        rep   = '0;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
        if (b == CH_CR)
            return;
        if (b == CH_LF) begin
            if (!link_seen && line_len != 0) begin
                link_seen      = 1'b1;
                rep.link_first = 1'b1;
            end
            // walk down so the highest priority class wins
            for (int k = int'(PFX_ZHOMED) - 1; k >= 0; k--) begin
                if (prefix_hit(k))
                    rep.kind = t_line_kind'(k + 1);
            end
            if (prefix_hit(int'(PFX_ZHOMED)))
                rep.zhome = quiet ? ZH_ACCEPT : ZH_IGNORED;
            if (scan_phase >= PH_SPACE) begin
                if (fault_neg)
                    code = (fault_mag >= 32'h8000_0000) ? 8'd0 : 8'(32'd0 - fault_mag);
                else
                    code = (fault_mag > 32'h7FFF_FFFF) ? 8'hFF : fault_mag[7:0];
                rep.fault_present = 1'b1;
                rep.fault_value   = code;
                rep.fault_alarm   = (code != 8'd0) && (last_fault == 8'd0);
                last_fault        = code;
            end
            rep.length = line_len[6:0];
            restart_line();
            awaited_reports.push_back(rep);
        end else if (line_len < LINE_BYTES - 1) begin
            // prefix compare at this position
            for (int k = 0; k < 7; k++) begin
                if (line_len < PREFIX_LEN[k] &&
                    b != PREFIX_TEXT[k][63 - 8 * int'(line_len) -: 8])
                    live_prefixes[k] = 1'b0;
            end
            // fault field scan; a zero byte hides the rest of the line
            if (!text_cut) begin
                if (b == CH_NUL) begin
                    text_cut = 1'b1;
                end else begin
                    case (scan_phase)
                        PH_SEARCH: begin
                            if (b == CH_F)
                                scan_phase = PH_SEENF;
                        end
                        PH_SEENF: begin
                            if (b == CH_COLON)
                                scan_phase = PH_SPACE;
                            else if (b != CH_F)
                                scan_phase = PH_SEARCH;
                        end
                        PH_SPACE: begin
                            if (blank) begin
                                scan_phase = PH_SPACE;
                            end else if (b == CH_PLUS) begin
                                scan_phase = PH_SIGN;
                            end else if (b == CH_MINUS) begin
                                fault_neg  = 1'b1;
                                scan_phase = PH_SIGN;
                            end else if (digit) begin
                                fault_mag  = grow_fault(fault_mag, b);
                                scan_phase = PH_DIGITS;
                            end else begin
                                scan_phase = PH_DONE;
                            end
                        end
                        PH_SIGN: begin
                            if (digit) begin
                                fault_mag  = grow_fault(fault_mag, b);
                                scan_phase = PH_DIGITS;
                            end else begin
                                scan_phase = PH_DONE;
                            end
                        end
                        PH_DIGITS: begin
                            if (digit)
                                fault_mag = grow_fault(fault_mag, b);
                            else
                                scan_phase = PH_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            line_len++;
        end else begin
            // buffer full: line dropped, byte lost
            restart_line();
            rep.overflowed = 1'b1;
            awaited_reports.push_back(rep);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    // Compare result beats first, then predict from the byte beat of this edge
    always @(posedge i_clk) begin : watch
        t_line_report want;
        if (!i_rst_n) begin
            restart_line();
            last_fault = '0;
            link_seen  = 1'b0;
            awaited_reports.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (awaited_reports.size() == 0) begin
                    $error("result beat with no line report awaiting it");
                    fail_total++;
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("line_kind", want.kind, i_line_kind);
                    check_field("overflowed", want.overflowed, i_overflowed);
                    check_field("link_first", want.link_first, i_link_first);
                    check_field("zhome_status", want.zhome, i_zhome_status);
                    check_field("fault_present", want.fault_present, i_fault_present);
                    check_field("fault_value", want.fault_value, i_fault_value);
                    check_field("fault_alarm", want.fault_alarm, i_fault_alarm);
                    check_field("line_length", want.length, i_line_length);
                end
            end
            if (i_byte_valid && i_byte_ready)
                take_byte(i_rx_byte, i_machine_quiet);
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_reports.size();
    end

endmodule

// File: verif/testbench.sv
// Testbench top for the status line parser: clock, reset, byte stimulus,
// result stall pattern, watchdog and verdict.
// Depends on slp_pkg, status_line_parser_unit and slp_line_checker.
module testbench;
    import slp_pkg::*;

    localparam int RANDOM_BYTES = 780;
    localparam int CALM_BYTES   = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic [7:0] i_rx_byte       = '0;
    logic       i_machine_quiet = 1'b0;
    logic       i_ready         = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [2:0] o_line_kind;
    logic       o_overflowed;
    logic       o_link_first;
    logic [1:0] o_zhome_status;
    logic       o_fault_present;
    logic [7:0] o_fault_value;
    logic       o_fault_alarm;
    logic [6:0] o_line_length;

    int fail_count;
    int pending;

    // Stimulus pacing shared between the sender and the receiver
    logic        calm       = 1'b0;
    logic        hold_req   = 1'b0;
    int unsigned gap_odds   = 0;
    int unsigned beat_count = 0;
    int unsigned bytes_sent = 0;
    int          idle_run   = 0;

    string prefix_words [7] = '{"OTA_IP:", "OTA_ERR:", "OTA_END:", "ERR:",
                                "WARN:", "MSG:", "ZHOMED"};

    status_line_parser_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .i_machine_quiet(i_machine_quiet),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_line_kind    (o_line_kind),
        .o_overflowed   (o_overflowed),
        .o_link_first   (o_link_first),
        .o_zhome_status (o_zhome_status),
        .o_fault_present(o_fault_present),
        .o_fault_value  (o_fault_value),
        .o_fault_alarm  (o_fault_alarm),
        .o_line_length  (o_line_length)
    );

    slp_line_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (i_valid),
        .i_byte_ready   (o_ready),
        .i_rx_byte      (i_rx_byte),
        .i_machine_quiet(i_machine_quiet),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_line_kind    (o_line_kind),
        .i_overflowed   (o_overflowed),
        .i_link_first   (o_link_first),
        .i_zhome_status (o_zhome_status),
        .i_fault_present(o_fault_present),
        .i_fault_value  (o_fault_value),
        .i_fault_alarm  (o_fault_alarm),
        .i_line_length  (o_line_length),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 12-unit clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // One byte beat, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic quiet);
        if (beat_count % 64 == 0) begin
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 12;
            endcase
        end
        beat_count++;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_rx_byte       <= b;
        i_machine_quiet <= quiet;
        do @(posedge i_clk); while (!o_ready);
        if (b != CH_CR)
            bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], coin());
    endtask

    task automatic send_line(input string s, input logic quiet);
        send_text(s);
        send_byte(CH_LF, quiet);
    endtask

    // Random printable text with the odd carriage return, tab or zero byte
    task automatic send_filler();
        int unsigned n;
        n = $urandom_range(0, 4);
        repeat (n) begin
            case ($urandom_range(0, 19))
                0:       send_byte(CH_CR, coin());
                1:       send_byte(CH_NUL, coin());
                2:       send_byte(CH_TAB, coin());
                default: send_byte(8'($urandom_range(32, 126)), coin());
            endcase
        end
    endtask

    // Mostly well-formed status lines with random content, some noise
    task automatic send_random_line();
        int unsigned shape;
        int unsigned n;
        int unsigned k;
        int unsigned cut;
        int unsigned flip;
        string       word;
        logic [7:0]  c;
        logic        quiet;
        quiet = coin();
        shape = $urandom_range(0, 39);
        if (shape == 0) begin
            // long run, usually past the buffer limit
            n = $urandom_range(110, 160);
            repeat (n) send_byte(8'($urandom_range(32, 126)), coin());
        end else if (shape < 7) begin
            // raw noise over the whole byte range
            n = $urandom_range(0, 16);
            repeat (n) send_byte(8'($urandom_range(0, 255)), coin());
        end else begin
            k = $urandom_range(0, 7);
            if (k < 7) begin
                // prefix, now and then cut short or with one bit flipped
                word = prefix_words[k];
                cut  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, word.len())
                                                   : word.len();
                flip = ($urandom_range(0, 5) == 0) ? $urandom_range(0, word.len() - 1)
                                                   : word.len();
                for (int i = 0; i < cut; i++) begin
                    c = word[i];
                    if (i == flip)
                        c ^= 8'(1 << $urandom_range(0, 7));
                    send_byte(c, coin());
                end
            end
            send_filler();
            if ($urandom_range(0, 2) != 0) begin
                // fault field: blanks, sign, digits
                if ($urandom_range(0, 5) == 0)
                    send_byte(CH_F, coin());
                send_byte(CH_F, coin());
                send_byte(CH_COLON, coin());
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0:       send_byte(CH_SPACE, coin());
                        1:       send_byte(CH_TAB, coin());
                        2:       send_byte(CH_VT, coin());
                        default: send_byte(CH_FF, coin());
                    endcase
                end
                case ($urandom_range(0, 5))
                    0:       send_byte(CH_PLUS, coin());
                    1:       send_byte(CH_MINUS, coin());
                    default: ;
                endcase
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12)
                                                : $urandom_range(1, 3);
                repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), coin());
            end
            send_filler();
        end
        send_byte(CH_LF, quiet);
    endtask

    // Result side: random stalls, one long hold-off on request, none when calm
    initial begin : result_side
        int unsigned stall_odds;
        stall_odds = 4;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 2;
                    default: stall_odds = 6;
                endcase
            end
            if (hold_req) begin
                // block fills and must stall the byte input
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_run <= 0;
        end else if (idle_run + 1 >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Reset, directed lines, random lines, drain and verdict
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(CH_LF, 1'b1);                 // empty line, link not yet up
        send_line("OTA_IP:10.0.0.7", 1'b1);     // first text line confirms link
        send_line("OTA_ERR:auth", 1'b0);
        send_line("OTA_END:", 1'b1);
        send_line("ERR:F:7", 1'b0);             // fault rises from zero
        send_line("WARN:F:0", 1'b0);
        send_line("MSG:F:  -3", 1'b1);          // negative wraps to low byte
        send_line("ZHOMED", 1'b1);              // machine quiet: accepted
        send_line("ZHOMED busy", 1'b0);         // machine busy: ignored
        send_line("F:2147483647", 1'b0);
        send_line("F:99999999999", 1'b0);       // saturates high
        send_line("F:-2147483648", 1'b0);
        send_line("F:-99999999999", 1'b0);      // saturates low
        send_line("F:+", 1'b1);                 // sign with no digits
        send_line("FF:12 F:34", 1'b0);          // only the first field counts
        // every blank kind ahead of the digits, carriage return ignored
        send_text("F:");
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_VT, 1'b1);
        send_byte(CH_FF, 1'b0);
        send_byte(CH_SPACE, 1'b1);
        send_byte(CH_CR, 1'b0);
        send_line("42", 1'b1);
        // zero byte hides both prefix and fault field
        send_text("WA");
        send_byte(CH_NUL, 1'b0);
        send_line("RN:F:5", 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(CH_LF, 1'b1);
        send_line("OTA_I", 1'b1);
        send_line("ERR", 1'b0);
        // longest line that fits, then one byte past it, then a restart
        repeat (LINE_BYTES_DEF - 1) send_byte("Z", coin());
        send_byte(CH_LF, 1'b0);
        repeat (LINE_BYTES_DEF) send_byte("a", coin());
        send_byte(CH_LF, 1'b1);
        repeat (LINE_BYTES_DEF + 2) send_byte("b", coin());
        send_byte(CH_LF, 1'b0);

        bytes_sent = 0;
        for (int n = 0; bytes_sent < RANDOM_BYTES; n++) begin
            if (n == 12)
                hold_req = 1'b1;
            if (bytes_sent >= RANDOM_BYTES - CALM_BYTES)
                calm = 1'b1;
            send_random_line();
        end
        i_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
